// ----- rtl/pbcd_pkg.sv -----
package pbcd_pkg;

  localparam int MAX_OUT_BYTES = 32;
  localparam int LEFT_W = $clog2(MAX_OUT_BYTES + 1);
  localparam int CFG_W = 6;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  localparam logic [3:0] NIB_ZERO   = 4'h0;
  localparam logic [3:0] NIB_POINT  = 4'hA;
  localparam logic [3:0] NIB_SIGN_P = 4'hB;
  localparam logic [3:0] NIB_SIGN_M = 4'hC;
  localparam logic [3:0] NIB_BAD_D  = 4'hD;
  localparam logic [3:0] NIB_BAD_E  = 4'hE;
  localparam logic [3:0] NIB_END    = 4'hF;
  localparam logic [7:0] PAD_BYTE   = 8'hFF;

  typedef struct packed {
    logic [3:0] nibble;
    logic       last_nibble;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       format_error;
    logic       number_done;
  } out_item_t;

  typedef enum logic {
    PH_NIBBLE,
    PH_CLOSE
  } phase_e;

  function automatic logic [LEFT_W-1:0] clamp_len(input logic [CFG_W-1:0] n);
    logic [LEFT_W-1:0] r;
    if (n == '0) begin
      r = LEFT_W'(1);
    end else if (int'(n) > MAX_OUT_BYTES) begin
      r = LEFT_W'(MAX_OUT_BYTES);
    end else begin
      r = LEFT_W'(n);
    end
    return r;
  endfunction

endpackage

// ----- rtl/pbcd_in_stage.sv -----
module pbcd_in_stage import pbcd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_data_i,
  output logic     in_stall_o,
  input  logic     consume_i,
  output logic     item_valid_o,
  output in_item_t item_o
);

  logic     valid_q;
  in_item_t item_q;

  assign in_stall_o   = valid_q && !consume_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

endmodule

// ----- rtl/pbcd_core.sv -----
module pbcd_core import pbcd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] out_len_i,
  input  logic             item_valid_i,
  input  in_item_t         item_i,
  input  logic             out_free_i,
  output logic             consume_o,
  output logic             emit_o,
  output out_item_t        result_o
);

  phase_e            phase_q, phase_d;
  logic              active_q, active_d;
  logic              half_q, half_d;
  logic [3:0]        held_q, held_d;
  logic              sig_q, sig_d;
  logic [LEFT_W-1:0] left_q, left_d;
  logic              fin_q, fin_d;

  // state seen by the current request, cleared at the start of a number
  logic              e_half, e_sig, e_fin;
  logic [3:0]        e_held;
  logic [LEFT_W-1:0] e_left;

  // outcome of the nibble step
  logic              n_half, n_sig, n_fin, n_emit, n_close;
  logic [3:0]        n_held;
  logic [LEFT_W-1:0] n_left;
  out_item_t         n_res;
  logic              nb_emit;
  logic [7:0]        nb_byte;
  logic [3:0]        nib;

  assign nib = item_i.nibble;

  always_comb begin
    if (phase_q == PH_NIBBLE && !active_q) begin
      e_half = 1'b0;
      e_held = NIB_ZERO;
      e_sig  = 1'b0;
      e_fin  = 1'b0;
      e_left = clamp_len(out_len_i);
    end else begin
      e_half = half_q;
      e_held = held_q;
      e_sig  = sig_q;
      e_fin  = fin_q;
      e_left = left_q;
    end
  end

  always_comb begin
    n_half  = e_half;
    n_held  = e_held;
    n_sig   = e_sig;
    n_fin   = e_fin;
    n_left  = e_left;
    n_emit  = 1'b0;
    n_res   = '0;
    nb_emit = 1'b0;
    nb_byte = {e_held, nib};
    if (!e_fin) begin
      if (nib inside {NIB_BAD_D, NIB_BAD_E}) begin
        n_emit             = 1'b1;
        n_res.format_error = 1'b1;
        n_res.number_done  = 1'b1;
        n_fin              = 1'b1;
      end else if (nib inside {NIB_SIGN_P, NIB_SIGN_M} ||
                   (nib < NIB_POINT && e_sig)) begin
        if (!e_half) begin
          n_held = nib;
          n_half = 1'b1;
        end else begin
          nb_emit = 1'b1;
          n_half  = 1'b0;
        end
      end else if (nib < NIB_POINT && nib != NIB_ZERO) begin
        // first significant digit, a point follows it
        n_sig   = 1'b1;
        nb_emit = 1'b1;
        n_held  = NIB_POINT;
        n_half  = 1'b1;
      end
    end
    if (nb_emit) begin
      n_emit           = 1'b1;
      n_res.out_byte   = nb_byte;
      n_res.byte_valid = 1'b1;
      n_left           = e_left - LEFT_W'(1);
      if (e_left == LEFT_W'(1)) begin
        n_fin             = 1'b1;
        n_res.number_done = 1'b1;
      end
    end
    n_close = !n_fin && (item_i.last_nibble || nib == NIB_END);
  end

  always_comb begin
    phase_d   = phase_q;
    active_d  = active_q;
    half_d    = half_q;
    held_d    = held_q;
    sig_d     = sig_q;
    left_d    = left_q;
    fin_d     = fin_q;
    consume_o = 1'b0;
    emit_o    = 1'b0;
    result_o  = n_res;
    if (item_valid_i) begin
      case (phase_q)
        PH_NIBBLE: begin
          if (!n_emit || out_free_i) begin
            emit_o   = n_emit;
            active_d = 1'b1;
            half_d   = n_half;
            held_d   = n_held;
            sig_d    = n_sig;
            left_d   = n_left;
            fin_d    = n_fin;
            if (n_close) begin
              phase_d = PH_CLOSE;
            end else begin
              consume_o = 1'b1;
              if (item_i.last_nibble) begin
                active_d = 1'b0;
              end
            end
          end
        end
        PH_CLOSE: begin
          result_o            = '0;
          result_o.out_byte   = half_q ? {held_q, NIB_END} : PAD_BYTE;
          result_o.byte_valid = 1'b1;
          if (out_free_i) begin
            emit_o = 1'b1;
            half_d = 1'b0;
            left_d = left_q - LEFT_W'(1);
            if (left_q == LEFT_W'(1)) begin
              result_o.number_done = 1'b1;
              fin_d                = 1'b1;
              phase_d              = PH_NIBBLE;
              consume_o            = 1'b1;
              if (item_i.last_nibble) begin
                active_d = 1'b0;
              end
            end
          end
        end
        default: begin
          phase_d = PH_NIBBLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_NIBBLE;
      active_q <= 1'b0;
      half_q   <= 1'b0;
      held_q   <= NIB_ZERO;
      sig_q    <= 1'b0;
      left_q   <= clamp_len(CFG_RESET);
      fin_q    <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      active_q <= active_d;
      half_q   <= half_d;
      held_q   <= held_d;
      sig_q    <= sig_d;
      left_q   <= left_d;
      fin_q    <= fin_d;
    end
  end

endmodule

// ----- rtl/pbcd_out_stage.sv -----
module pbcd_out_stage import pbcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      emit_i,
  input  out_item_t result_i,
  output logic      out_free_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i
);

  logic      valid_q;
  out_item_t data_q;

  assign out_free_o  = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free_o) begin
      valid_q <= emit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free_o && emit_i) begin
      data_q <= result_i;
    end
  end

endmodule

// ----- rtl/packed_bcd_normalizer.sv -----
// a result goes from the core into the output register, which drives out_valid_o and out_data_o
// throughput: one nibble per cycle while each nibble gives at most one result and the output is not stalled
// closing a number sends one pad byte per cycle from the core while the output is free; the input holds
// meanwhile, until the number has all of its output_length bytes
// reset: rst_ni asynchronous active low clears all control state, output_length becomes 8
module packed_bcd_normalizer import pbcd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  input  in_item_t         in_data_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  output out_item_t        out_data_o,
  input  logic             out_stall_i
);

  logic [CFG_W-1:0] out_len_q;
  logic             item_valid;
  in_item_t         item;
  logic             consume;
  logic             emit;
  out_item_t        result;
  logic             out_free;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_len_q <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      out_len_q <= cfg_data_i;
    end
  end

  pbcd_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .consume_i   (consume),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  pbcd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .out_len_i   (out_len_q),
    .item_valid_i(item_valid),
    .item_i      (item),
    .out_free_i  (out_free),
    .consume_o   (consume),
    .emit_o      (emit),
    .result_o    (result)
  );

  pbcd_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .emit_i     (emit),
    .result_i   (result),
    .out_free_o (out_free),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_stall_i(out_stall_i)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) emit |-> out_free)
    else $error("result produced while output register is occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      item_valid && !consume |=> item_valid)
    else $error("held request dropped without being consumed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      emit && result.format_error |-> result.number_done && !result.byte_valid)
    else $error("error result must close the number without a byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni) consume |-> item_valid)
    else $error("consume without a held request");
`endif

endmodule
